// ===== src/pnrd_pkg.sv =====
// ----------------------------------------------------------------------------
// pnrd_pkg
// Shared constants, state type and saturation helper for the Newton root
// finder with Horner deflation.
// ----------------------------------------------------------------------------
package pnrd_pkg;

  localparam int DEGREE    = 4;
  localparam int FRAC_BITS = 20;
  localparam int PART_W    = 32;
  localparam int DEG_W     = 3;
  localparam int ITER_W    = 8;
  localparam int WIDE_W    = 66;
  localparam int PROD_W    = 2 * PART_W;
  localparam int NUM_W     = PROD_W + FRAC_BITS;
  localparam int CNT_W     = 7;

  localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(20);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT,
    ST_STEP,
    ST_CMUL,
    ST_CADD,
    ST_DMUL,
    ST_DCHK,
    ST_DRE,
    ST_DIM,
    ST_UPD,
    ST_EMIT,
    ST_DEFL
  } state_t;

  // Clamp a wide signed value to one signed part.
  function automatic logic signed [PART_W-1:0] sat_part(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'((65'sd1 <<< (PART_W - 1)) - 65'sd1);
    lo = -hi - WIDE_W'(1);
    if (v > hi) begin
      return hi[PART_W-1:0];
    end else if (v < lo) begin
      return lo[PART_W-1:0];
    end
    return v[PART_W-1:0];
  endfunction

endpackage

// ===== src/pnrd_div.sv =====
// ----------------------------------------------------------------------------
// pnrd_div
// Bit-serial restoring divider: (mag << FRAC_BITS) / den, truncated, with
// sign applied and the result saturated to one signed part.
// ----------------------------------------------------------------------------
module pnrd_div
  import pnrd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     neg,
  input  logic [PROD_W-1:0]        mag,
  input  logic [PROD_W-1:0]        den,
  output logic                     done,
  output logic signed [PART_W-1:0] quo
);

  localparam logic [PART_W-1:0] CAP = PART_W'(1) << (PART_W - 1);

  logic [NUM_W-1:0]  num;
  logic [PROD_W:0]   rem;
  logic [PART_W:0]   q;
  logic              ovf;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              neg_r;
  logic [PROD_W-1:0] den_r;

  logic [PROD_W:0]   r2;
  logic              qbit;
  logic              big;
  logic [PART_W-1:0] qm;

  // One quotient bit per cycle
  always_comb begin
    r2   = {rem[PROD_W-1:0], num[NUM_W-1]};
    qbit = (r2 >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num   <= {mag, {FRAC_BITS{1'b0}}};
      rem   <= '0;
      q     <= '0;
      ovf   <= 1'b0;
      neg_r <= neg;
      den_r <= den;
    end else if (busy) begin
      num <= num << 1;
      rem <= qbit ? (r2 - {1'b0, den_r}) : r2;
      ovf <= ovf | q[PART_W];
      q   <= {q[PART_W-1:0], qbit};
    end
  end

  // Cap the magnitude, then sign and saturate
  always_comb begin
    big = ovf || q[PART_W] || (q[PART_W-1:0] > CAP);
    qm  = big ? CAP : q[PART_W-1:0];
    if (neg_r) begin
      quo = -qm;
    end else begin
      quo = qm[PART_W-1] ? (CAP - PART_W'(1)) : qm;
    end
  end

endmodule

// ===== src/polynomial_root_newton_deflate_core.sv =====
// ----------------------------------------------------------------------------
// polynomial_root_newton_deflate_core
// Newton-Raphson roots of a complex quartic with Horner deflation, Q11.20.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_*: tuser[0]=0 loads coefficient tdata[2:0] (power of z)
//   with value tdata[34:3] (re) and tdata[66:35] (im); tuser[0]=1 starts a
//   solve with that value as first guess.
//   A start emits four root beats on m_*, root_order 0..3, tlast on the
//   fourth. The stored polynomial stays deflated after a run.
//   A Newton step at degree d runs value and slope Horner passes on one
//   shared 32x32 multiplier, then two bit-serial divides. A step with a
//   zero slope skips the divides. A run takes max_iterations steps (at
//   least one) for each degree d = 4..1. s_tready is low for the whole run.
//   A result waits in the output register while the next root is worked on;
//   if the receiver stalls, the block holds before emitting the next root.
//   Reset (rst, synchronous) returns to idle, max_iterations to 20, drops
//   any pending result. Coefficients are undefined until loaded.
// ----------------------------------------------------------------------------
module polynomial_root_newton_deflate_core
  import pnrd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [71:0]       s_tdata,   // coef_index[2:0], value_re[34:3], value_im[66:35]
  input  logic [0:0]        s_tuser,   // command
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [71:0]       m_tdata,   // root_re[31:0], root_im[63:32], root_order[65:64]
  output logic [0:0]        m_tuser,   // zero_slope
  output logic              m_tlast,   // last
  input  logic              cfg_wen,
  input  logic [ITER_W-1:0] cfg_wdata
);

  state_t state, state_next;

  logic [ITER_W-1:0] max_iter;
  logic [ITER_W-1:0] iters;
  logic [ITER_W-1:0] step;
  logic [DEG_W-1:0]  deg;
  logic [DEG_W-1:0]  j;
  logic [2:0]        ph;
  logic              pass;
  logic              flat;
  logic              dzero;

  logic signed [PART_W-1:0] a_re [0:DEGREE];
  logic signed [PART_W-1:0] a_im [0:DEGREE];
  logic signed [PART_W-1:0] b_re [0:DEGREE];
  logic signed [PART_W-1:0] b_im [0:DEGREE];

  logic signed [PART_W-1:0] guess_re, guess_im;
  logic signed [PART_W-1:0] z_re, z_im;
  logic signed [PART_W-1:0] acc_re, acc_im;
  logic signed [PART_W-1:0] val_re, val_im;
  logic signed [PART_W-1:0] t_re, t_im;
  logic signed [PART_W-1:0] d_re, d_im;
  logic signed [WIDE_W-1:0] sum;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W:0]   dsum;
  logic [PROD_W-1:0]        den;
  logic signed [PROD_W:0]   nre, nim;

  logic [DEG_W-1:0]         in_idx;
  logic signed [PART_W-1:0] in_re, in_im;

  logic signed [PART_W-1:0] mul_a, mul_b;
  logic signed [WIDE_W-1:0] fs;
  logic signed [PART_W-1:0] add_re, add_im;
  logic signed [PART_W-1:0] nr_re, nr_im;
  logic [DEG_W-1:0]         jm1;

  logic                     div_start;
  logic                     div_neg;
  logic [PROD_W-1:0]        div_mag;
  logic signed [PROD_W:0]   div_src;
  logic                     div_done;
  logic signed [PART_W-1:0] div_quo;
  logic                     out_load;

  assign in_idx = s_tdata[2:0];
  assign in_re  = s_tdata[34:3];
  assign in_im  = s_tdata[66:35];

  assign iters    = (max_iter == '0) ? ITER_W'(1) : max_iter;
  assign s_tready = (state == ST_IDLE);
  assign jm1      = j - DEG_W'(1);
  assign out_load = (state == ST_EMIT) && (!m_tvalid || m_tready);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid && s_tuser[0]) state_next = ST_ROOT;
      ST_ROOT: state_next = ST_STEP;
      ST_STEP: state_next = ST_CMUL;
      ST_CMUL: if (ph == 3'd4) state_next = ST_CADD;
      ST_CADD: begin
        if (j == '0 && pass) begin
          state_next = ST_DMUL;
        end else begin
          state_next = ST_CMUL;
        end
      end
      ST_DMUL: if (ph == 3'd6) state_next = ST_DCHK;
      ST_DCHK: state_next = (den == '0) ? ST_UPD : ST_DRE;
      ST_DRE:  if (div_done) state_next = ST_DIM;
      ST_DIM:  if (div_done) state_next = ST_UPD;
      ST_UPD:  state_next = (step + ITER_W'(1) == iters) ? ST_EMIT : ST_STEP;
      ST_EMIT: if (!m_tvalid || m_tready) state_next = ST_DEFL;
      ST_DEFL: state_next = (deg == DEG_W'(1)) ? ST_IDLE : ST_ROOT;
      default: state_next = ST_IDLE;
    endcase
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = acc_re;
    mul_b = z_re;
    if (state == ST_CMUL) begin
      unique case (ph)
        3'd0:    begin mul_a = acc_re; mul_b = z_re; end
        3'd1:    begin mul_a = acc_im; mul_b = z_im; end
        3'd2:    begin mul_a = acc_re; mul_b = z_im; end
        default: begin mul_a = acc_im; mul_b = z_re; end
      endcase
    end else begin
      unique case (ph)
        3'd0:    begin mul_a = acc_re; mul_b = acc_re; end
        3'd1:    begin mul_a = acc_im; mul_b = acc_im; end
        3'd2:    begin mul_a = val_re; mul_b = acc_re; end
        3'd3:    begin mul_a = val_im; mul_b = acc_im; end
        3'd4:    begin mul_a = val_im; mul_b = acc_re; end
        default: begin mul_a = val_re; mul_b = acc_im; end
      endcase
    end
  end

  // Floored product and Horner add
  always_comb begin
    fs     = WIDE_W'(prod >>> FRAC_BITS);
    add_re = pass ? b_re[j] : a_re[j];
    add_im = pass ? b_im[j] : a_im[j];
    nr_re  = sat_part(WIDE_W'(add_re) + WIDE_W'(t_re));
    nr_im  = sat_part(WIDE_W'(add_im) + WIDE_W'(t_im));
  end

  // Divider feed: real part from the check state, imaginary part after
  always_comb begin
    div_start = ((state == ST_DCHK) && (den != '0)) || ((state == ST_DRE) && div_done);
    div_src   = (state == ST_DCHK) ? nre : nim;
    div_neg   = div_src[PROD_W];
    div_mag   = div_neg ? PROD_W'(-div_src) : div_src[PROD_W-1:0];
  end

  pnrd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .neg   (div_neg),
    .mag   (div_mag),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter <= ITER_RESET;
      step     <= '0;
      deg      <= '0;
      j        <= '0;
      ph       <= '0;
      pass     <= 1'b0;
      flat     <= 1'b0;
      dzero    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        max_iter <= cfg_wdata;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: if (s_tvalid && s_tuser[0]) deg <= DEG_W'(DEGREE);
        ST_ROOT: begin
          step <= '0;
          flat <= 1'b0;
        end
        ST_STEP: begin
          j    <= deg;
          pass <= 1'b0;
          ph   <= '0;
        end
        ST_CMUL: ph <= ph + 3'd1;
        ST_CADD: begin
          ph <= '0;
          if (j == '0 && !pass) begin
            pass <= 1'b1;
            j    <= deg - DEG_W'(1);
          end else if (j != '0) begin
            j <= jm1;
          end
        end
        ST_DMUL: ph <= ph + 3'd1;
        ST_DCHK: begin
          dzero <= (den == '0);
          if (den == '0) flat <= 1'b1;
        end
        ST_UPD:  step <= step + ITER_W'(1);
        ST_DEFL: deg <= deg - DEG_W'(1);
        default: ;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && !s_tuser[0] && in_idx <= DEG_W'(DEGREE)) begin
          a_re[in_idx] <= in_re;
          a_im[in_idx] <= in_im;
        end
        if (s_tvalid && s_tuser[0]) begin
          guess_re <= in_re;
          guess_im <= in_im;
        end
      end
      ST_ROOT: begin
        z_re <= guess_re;
        z_im <= guess_im;
      end
      ST_STEP: begin
        acc_re      <= '0;
        acc_im      <= '0;
        b_re[deg]   <= '0;
        b_im[deg]   <= '0;
      end
      ST_CMUL: begin
        unique case (ph)
          3'd0: ;
          3'd1: sum <= fs;
          3'd2: sum <= sum - fs;
          3'd3: begin
            t_re <= sat_part(sum);
            sum  <= fs;
          end
          default: t_im <= sat_part(sum + fs);
        endcase
      end
      ST_CADD: begin
        if (!pass && j == '0) begin
          val_re <= nr_re;
          val_im <= nr_im;
          acc_re <= '0;
          acc_im <= '0;
        end else begin
          acc_re <= nr_re;
          acc_im <= nr_im;
        end
        if (!pass && j != '0) begin
          b_re[jm1] <= nr_re;
          b_im[jm1] <= nr_im;
        end
      end
      ST_DMUL: begin
        unique case (ph)
          3'd0: ;
          3'd1: dsum <= (PROD_W + 1)'(prod);
          3'd2: den  <= PROD_W'((PROD_W + 1)'(dsum) + (PROD_W + 1)'(prod));
          3'd3: dsum <= (PROD_W + 1)'(prod);
          3'd4: nre  <= dsum + (PROD_W + 1)'(prod);
          3'd5: dsum <= (PROD_W + 1)'(prod);
          default: nim <= dsum - (PROD_W + 1)'(prod);
        endcase
      end
      ST_DRE: if (div_done) d_re <= div_quo;
      ST_DIM: if (div_done) d_im <= div_quo;
      ST_UPD: begin
        if (!dzero) begin
          z_re <= sat_part(WIDE_W'(z_re) - WIDE_W'(d_re));
          z_im <= sat_part(WIDE_W'(z_im) - WIDE_W'(d_im));
        end
      end
      ST_DEFL: begin
        for (int k = 0; k < DEGREE; k++) begin
          a_re[k] <= b_re[k];
          a_im[k] <= b_im[k];
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'd0, 2'(DEGREE - int'(deg)), z_im, z_re};
      m_tuser <= flat;
      m_tlast <= (deg == DEG_W'(1));
    end
  end

endmodule

// ===== src/pnrd_checker.sv =====
// ----------------------------------------------------------------------------
// pnrd_props
// Port-level checks on the root finder, bound to the top level.
// ----------------------------------------------------------------------------
module pnrd_props (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic        m_tlast
);

  // Hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  // The final root of a run is the fourth
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[65:64] == 2'd3)
    else $error("tlast on a root other than the fourth");

  a_notlast: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[65:64] != 2'd3)
    else $error("fourth root without tlast");

  // A start beat takes the input side busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
    else $error("input accepted right after a start beat");

endmodule

bind polynomial_root_newton_deflate_core pnrd_props u_pnrd_props (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
